// ===== rtl/core/stwt_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants, register map and types for the time-window taper.
// No dependencies; every other file in rtl/core imports this package.

package stwt_pkg;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 16;
    localparam int LEN_W      = 32;
    localparam int RATE_W     = 24;
    localparam int MODE_W     = 2;
    localparam int TIME_W     = IDX_W + LEN_W;
    localparam int TAPER_W    = 17;
    localparam int FRAC_BITS  = 20;
    localparam int EXC_W      = 40;
    localparam int HALF_W     = EXC_W / 2;
    localparam int PROD_W     = RATE_W + HALF_W;
    localparam int SUM_W      = RATE_W + EXC_W;
    localparam int X_W        = SUM_W - FRAC_BITS;
    localparam int R_W        = 25;
    localparam int E_W        = 24;

    // taper: products, exponent, one stage per exponent bit, rounding
    localparam int TAPER_LAT  = FRAC_BITS + 3;
    // input stage, two excess stages, taper, three combine stages
    localparam int PIPE_DEPTH = TAPER_LAT + 6;
    localparam int SIDE_DEPTH = TAPER_LAT + 2;

    localparam int MAX_SAMPLES = 65536;
    localparam int IDX_CMP_W   = ($clog2(MAX_SAMPLES + 1) > IDX_W) ?
                                 $clog2(MAX_SAMPLES + 1) : IDX_W + 1;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRACE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUAL  = 2'd2;

    localparam logic [LEN_W-1:0]  RST_PERIOD = 32'd1049;
    localparam logic [RATE_W-1:0] RST_RATE   = 24'd65536;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_PERIOD = 3'd1,
        REG_RATE   = 3'd2,
        REG_AFTER  = 3'd3,
        REG_BEFORE = 3'd4
    } t_reg_idx;

    // exp(-2^(k-16)) in Q0.24, one entry per exponent bit
    localparam logic [E_W-1:0] EXP_BIT_TABLE [FRAC_BITS] = '{
        24'd16776960, 24'd16776704, 24'd16776192, 24'd16775168, 24'd16773120,
        24'd16769026, 24'd16760840, 24'd16744480, 24'd16711808, 24'd16646655,
        24'd16517109, 24'd16261035, 24'd15760736, 24'd14805841, 24'd13066109,
        24'd10175896, 24'd6171993,  24'd2270549,  24'd307285,   24'd5628
    };

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  period;
        logic [RATE_W-1:0] rate;
        logic [LEN_W-1:0]  fix_after;
        logic [LEN_W-1:0]  fix_before;
    } t_cfg;

    // lead is the window length ahead of the pick
    typedef struct packed {
        logic [LEN_W-1:0] pick;
        logic [LEN_W-1:0] after;
        logic [LEN_W-1:0] lead;
    } t_win;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     pass;
        logic                     dual;
    } t_side;

endpackage

// ===== rtl/core/seismic_time_window_taper_top.sv =====
`timescale 1ns / 1ps
// Top level of the seismic time-window taper: handshake, input stage, pipeline.
// Depends on stwt_pkg, stwt_regs, stwt_excess, stwt_taper and stwt_combine.

// Exponential time-window taper for a stream of seismic trace samples. Each
// sample transfer carries the amplitude, its one-based index and the picks and
// window lengths of its trace; each gives exactly one tapered sample, in order.
// The block takes one sample per clock and holds no state between samples, so
// samples from different traces may be freely interleaved. There are 29
// register stages; the depth is set by the 20-stage exponential chain (one
// exponent bit and one multiply per stage) plus input, two window-edge, product,
// exponent, taper rounding and three scaling stages. Both channels are
// valid/ready; while a finished result is held off in the final stage the whole
// pipeline stalls in place and the input is held off too, and nothing is
// dropped or repeated. While the final stage is empty the pipeline keeps
// advancing whatever the output side does. Configuration goes through the APB
// port at byte address 4*i (mode, sample period, damping rate, fixed after
// length, fixed before length); write it only while the pipeline is empty.

module seismic_time_window_taper_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [stwt_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [stwt_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [stwt_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,

    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [stwt_pkg::DATA_W-1:0]    i_sample_value,
    input  logic [stwt_pkg::IDX_W-1:0]            i_sample_index,
    input  logic [stwt_pkg::LEN_W-1:0]            i_first_pick,
    input  logic [stwt_pkg::LEN_W-1:0]            i_first_after,
    input  logic [stwt_pkg::LEN_W-1:0]            i_first_before,
    input  logic [stwt_pkg::LEN_W-1:0]            i_second_pick,
    input  logic [stwt_pkg::LEN_W-1:0]            i_second_after,
    input  logic [stwt_pkg::LEN_W-1:0]            i_second_before,

    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [stwt_pkg::DATA_W-1:0]    o_tapered_value
);
    import stwt_pkg::*;

    t_cfg              w_cfg;
    logic              w_en;
    logic              w_fixed;
    logic              w_dual;
    logic [TIME_W-1:0] n_t;
    t_win              n_win1;
    t_win              n_win2;
    t_side             n_side;

    logic              r_vld [PIPE_DEPTH];
    logic [TIME_W-1:0] r_a_t;
    t_win              r_a_win1;
    t_win              r_a_win2;
    t_side             r_a_side;
    t_side             r_side [SIDE_DEPTH];

    logic [TIME_W-1:0]  w_exc1;
    logic [TIME_W-1:0]  w_exc2;
    logic [TAPER_W-1:0] w_taper1;
    logic [TAPER_W-1:0] w_taper2;

    stwt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance every stage together unless a finished result is held off.
    assign w_en        = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    // Mode 3 behaves as fixed lengths.
    assign w_dual  = (w_cfg.mode == MODE_DUAL);
    assign w_fixed = (w_cfg.mode != MODE_TRACE) && !w_dual;

    // Sample time is exact: 16-bit index by 32-bit period.
    assign n_t = TIME_W'(i_sample_index) * TIME_W'(w_cfg.period);

    always_comb begin
        n_win1.pick   = i_first_pick;
        n_win1.after  = w_fixed ? w_cfg.fix_after  : i_first_after;
        n_win1.lead   = w_fixed ? w_cfg.fix_before : i_first_before;
        n_win2.pick   = i_second_pick;
        n_win2.after  = i_second_after;
        n_win2.lead   = i_second_before;
        n_side.value  = i_sample_value;
        // leading samples and those past the trace length pass untouched
        n_side.pass   = (i_sample_index < IDX_W'(2)) ||
                        (IDX_CMP_W'(i_sample_index) > IDX_CMP_W'(MAX_SAMPLES));
        n_side.dual   = w_dual;
    end

    // Valid bits: clear on reset, shift with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Input stage and the sideband delay that meets the tapers at combine.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_t     <= n_t;
            r_a_win1  <= n_win1;
            r_a_win2  <= n_win2;
            r_a_side  <= n_side;
            r_side[0] <= r_a_side;
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    stwt_excess u_exc1 (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_time   (r_a_t),
        .i_win    (r_a_win1),
        .o_excess (w_exc1)
    );

    stwt_excess u_exc2 (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_time   (r_a_t),
        .i_win    (r_a_win2),
        .o_excess (w_exc2)
    );

    stwt_taper u_taper1 (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_rate   (w_cfg.rate),
        .i_excess (w_exc1),
        .o_taper  (w_taper1)
    );

    stwt_taper u_taper2 (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_rate   (w_cfg.rate),
        .i_excess (w_exc2),
        .o_taper  (w_taper2)
    );

    stwt_combine u_combine (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_side   (r_side[SIDE_DEPTH-1]),
        .i_taper1 (w_taper1),
        .i_taper2 (w_taper2),
        .o_value  (o_tapered_value)
    );

endmodule

// ===== rtl/core/stwt_regs.sv =====
`timescale 1ns / 1ps
// APB configuration registers of the time-window taper.
// Depends on stwt_pkg.

module stwt_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stwt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [stwt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [stwt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output stwt_pkg::t_cfg                    o_cfg
);
    import stwt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_FIXED;
            r_cfg.period     <= RST_PERIOD;
            r_cfg.rate       <= RST_RATE;
            r_cfg.fix_after  <= '0;
            r_cfg.fix_before <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:   r_cfg.mode       <= pwdata[MODE_W-1:0];
                REG_PERIOD: r_cfg.period     <= pwdata[LEN_W-1:0];
                REG_RATE:   r_cfg.rate       <= pwdata[RATE_W-1:0];
                REG_AFTER:  r_cfg.fix_after  <= pwdata[LEN_W-1:0];
                REG_BEFORE: r_cfg.fix_before <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:   prdata = APB_DATA_W'(r_cfg.mode);
            REG_PERIOD: prdata = APB_DATA_W'(r_cfg.period);
            REG_RATE:   prdata = APB_DATA_W'(r_cfg.rate);
            REG_AFTER:  prdata = APB_DATA_W'(r_cfg.fix_after);
            REG_BEFORE: prdata = APB_DATA_W'(r_cfg.fix_before);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/stwt_excess.sv =====
`timescale 1ns / 1ps
// Two-stage window test for one pick: gives the time beyond the window edge.
// Depends on stwt_pkg.

module stwt_excess (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [stwt_pkg::TIME_W-1:0]  i_time,
    input  stwt_pkg::t_win               i_win,
    output logic [stwt_pkg::TIME_W-1:0]  o_excess
);
    import stwt_pkg::*;

    logic [TIME_W-1:0] r_t;
    logic [LEN_W:0]    r_late;
    logic [LEN_W-1:0]  r_lo;
    logic              r_lo_ok;
    logic [TIME_W-1:0] r_excess;
    logic [TIME_W:0]   w_da;
    logic [TIME_W:0]   w_db;

    // borrow out of each subtract says which side of the edge we are on
    assign w_da = {1'b0, r_t} - (TIME_W + 1)'(r_late);
    assign w_db = (TIME_W + 1)'(r_lo) - {1'b0, r_t};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= i_time;
            r_late  <= {1'b0, i_win.pick} + {1'b0, i_win.after};
            r_lo    <= i_win.pick - i_win.lead;
            r_lo_ok <= i_win.pick >= i_win.lead;
            // after edge wins; when both hold the excess is zero anyway
            if (!w_da[TIME_W]) begin
                r_excess <= w_da[TIME_W-1:0];
            end else if (r_lo_ok && !w_db[TIME_W]) begin
                r_excess <= w_db[TIME_W-1:0];
            end else begin
                r_excess <= '0;
            end
        end
    end

    assign o_excess = r_excess;

endmodule

// ===== rtl/core/stwt_taper.sv =====
`timescale 1ns / 1ps
// Pipelined exp(-rate * excess) taper, Q1.16, one exponent bit per stage.
// Depends on stwt_pkg.

module stwt_taper (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [stwt_pkg::RATE_W-1:0]  i_rate,
    input  logic [stwt_pkg::TIME_W-1:0]  i_excess,
    output logic [stwt_pkg::TAPER_W-1:0] o_taper
);
    import stwt_pkg::*;

    logic [PROD_W-1:0]    r_plo;
    logic [PROD_W-1:0]    r_phi;
    logic                 r_big;
    logic [SUM_W-1:0]     w_sum;
    logic [X_W-1:0]       w_x;
    logic [R_W-1:0]       r_r [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] r_x [FRAC_BITS];
    logic [R_W-1:0]       w_step [FRAC_BITS];
    logic [R_W+E_W-1:0]   w_mul [FRAC_BITS];
    logic [TAPER_W-1:0]   r_taper;

    // split the 40-bit excess so each multiply stays 24 x 20
    assign w_sum = SUM_W'(r_plo) + {r_phi, HALF_W'(0)} + (SUM_W'(1) << (FRAC_BITS - 1));
    assign w_x   = w_sum[SUM_W-1:FRAC_BITS];

    always_comb begin
        for (int k = 0; k < FRAC_BITS; k++) begin
            w_mul[k]  = (R_W + E_W)'(r_r[k]) * (R_W + E_W)'(EXP_BIT_TABLE[k])
                        + ((R_W + E_W)'(1) << (E_W - 1));
            w_step[k] = r_x[k][k] ? w_mul[k][R_W+E_W-1:E_W] : r_r[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= PROD_W'(i_rate) * PROD_W'(i_excess[HALF_W-1:0]);
            r_phi <= PROD_W'(i_rate) * PROD_W'(i_excess[EXC_W-1:HALF_W]);
            // a zero rate never damps, however large the excess
            r_big <= (|i_excess[TIME_W-1:EXC_W]) && (i_rate != '0);
            // a zero start stays zero through the chain, giving taper 0
            r_r[0] <= (r_big || (|w_x[X_W-1:FRAC_BITS])) ? '0 : (R_W'(1) << E_W);
            r_x[0] <= w_x[FRAC_BITS-1:0];
            for (int k = 0; k < FRAC_BITS; k++) begin
                r_r[k+1] <= w_step[k];
            end
            for (int k = 1; k < FRAC_BITS; k++) begin
                r_x[k] <= r_x[k-1];
            end
            r_taper <= TAPER_W'((r_r[FRAC_BITS] + R_W'(128)) >> 8);
        end
    end

    assign o_taper = r_taper;

endmodule

// ===== rtl/core/stwt_combine.sv =====
`timescale 1ns / 1ps
// Applies the two tapers to the sample and rounds; in dual mode sums and saturates,
// otherwise gives the first result; pass samples go out untouched. Depends on stwt_pkg.

module stwt_combine (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  stwt_pkg::t_side               i_side,
    input  logic [stwt_pkg::TAPER_W-1:0]  i_taper1,
    input  logic [stwt_pkg::TAPER_W-1:0]  i_taper2,
    output logic signed [stwt_pkg::DATA_W-1:0] o_value
);
    import stwt_pkg::*;

    localparam int P_W   = DATA_W + TAPER_W;
    localparam int Q_W   = DATA_W + 1;
    localparam int W_W   = DATA_W + 2;
    localparam int S_W   = DATA_W + 3;
    localparam int SH    = TAPER_W - 1;

    logic [DATA_W-1:0]        w_mag;
    logic [P_W-1:0]           r_p1;
    logic [P_W-1:0]           r_p2;
    logic                     r_neg;
    t_side                    r_side_d;
    t_side                    r_side_e;
    logic [Q_W-1:0]           w_q1;
    logic [Q_W-1:0]           w_q2;
    logic signed [W_W-1:0]    r_w1;
    logic signed [W_W-1:0]    r_w2;
    logic signed [S_W-1:0]    w_sum;
    logic signed [DATA_W-1:0] w_sat;
    logic signed [DATA_W-1:0] r_out;

    assign w_mag = i_side.value[DATA_W-1] ? $unsigned(-i_side.value)
                                          : $unsigned(i_side.value);
    assign w_q1  = Q_W'((r_p1 + (P_W'(1) << (SH - 1))) >> SH);
    assign w_q2  = Q_W'((r_p2 + (P_W'(1) << (SH - 1))) >> SH);
    assign w_sum = S_W'(r_w1) + S_W'(r_w2);

    always_comb begin
        if (w_sum[S_W-1:DATA_W-1] == '0 || w_sum[S_W-1:DATA_W-1] == '1) begin
            w_sat = w_sum[DATA_W-1:0];
        end else if (w_sum[S_W-1]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1     <= P_W'(w_mag) * P_W'(i_taper1);
            r_p2     <= P_W'(w_mag) * P_W'(i_taper2);
            r_neg    <= i_side.value[DATA_W-1];
            r_side_d <= i_side;

            r_w1     <= r_neg ? -$signed({1'b0, w_q1}) : $signed({1'b0, w_q1});
            r_w2     <= r_neg ? -$signed({1'b0, w_q2}) : $signed({1'b0, w_q2});
            r_side_e <= r_side_d;

            if (r_side_e.pass) begin
                r_out <= r_side_e.value;
            end else if (r_side_e.dual) begin
                r_out <= w_sat;
            end else begin
                r_out <= r_w1[DATA_W-1:0];
            end
        end
    end

    assign o_value = r_out;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for seismic_time_window_taper_top: sample stream in, tapered stream out.
// Depends on stwt_pkg and the RTL under rtl/core; predicts each tapered sample locally.

module tb;
    import stwt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;   // unused code, behaves as fixed
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE      = 40;                    // pipeline is 29 deep
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 700;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 130;

    // exp(-2^(k-16)) in Q0.24, one per exponent bit
    localparam logic [23:0] EXP_Q24 [20] = '{
        24'd16776960, 24'd16776704, 24'd16776192, 24'd16775168, 24'd16773120,
        24'd16769026, 24'd16760840, 24'd16744480, 24'd16711808, 24'd16646655,
        24'd16517109, 24'd16261035, 24'd15760736, 24'd14805841, 24'd13066109,
        24'd10175896, 24'd6171993,  24'd2270549,  24'd307285,   24'd5628
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
        logic [LEN_W-1:0]         first_pick;
        logic [LEN_W-1:0]         first_after;
        logic [LEN_W-1:0]         first_before;
        logic [LEN_W-1:0]         second_pick;
        logic [LEN_W-1:0]         second_after;
        logic [LEN_W-1:0]         second_before;
    } t_sample;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_tapered_value;
    t_sample               cur = '0;

    // local copy of the register file
    logic [MODE_W-1:0] cfg_mode   = MODE_FIXED;
    logic [31:0]       cfg_period = 32'd1049;
    logic [23:0]       cfg_rate   = 24'd65536;
    logic [31:0]       cfg_after  = '0;
    logic [31:0]       cfg_before = '0;

    t_sample                  samples_to_send[$];
    logic signed [DATA_W-1:0] tapered_due[$];

    int          queued_cnt = 0;
    int          in_cnt = 0;
    int          out_cnt = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_hold = 0;
    logic        in_taken = 1'b0;
    logic        long_hold_done = 1'b0;
    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;

    seismic_time_window_taper_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_value  (cur.value),
        .i_sample_index  (cur.index),
        .i_first_pick    (cur.first_pick),
        .i_first_after   (cur.first_after),
        .i_first_before  (cur.first_before),
        .i_second_pick   (cur.second_pick),
        .i_second_after  (cur.second_after),
        .i_second_before (cur.second_before),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_tapered_value (o_tapered_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    // Damping factor in Q1.16 for a given excess time (Q44.20 seconds).
    function automatic logic [16:0] taper_gain(input logic [63:0] excess);
        logic [64:0] prod;
        logic [63:0] x16;
        logic [63:0] r;
        int          k;
        if (cfg_rate == 0 || excess == 0) return 17'd65536;
        if (excess >= (64'd1 << 40)) return 17'd0;
        prod = 65'(cfg_rate) * 65'(excess);
        x16  = 64'((prod + (65'd1 << 19)) >> 20);
        if (x16 == 0) return 17'd65536;
        if (x16 >= (64'd1 << 20)) return 17'd0;
        r = 64'd1 << 24;
        for (k = 0; k < 20; k++) begin
            if (x16[k]) r = (r * 64'(EXP_Q24[k]) + (64'd1 << 23)) >> 24;
        end
        return 17'((r + 64'd128) >> 8);
    endfunction

    // Multiply by the taper, round half away from zero.
    function automatic logic signed [63:0] apply_gain(input logic signed [63:0] v,
                                                      input logic [16:0] g);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (v < 0) ? -v : v;
        q   = (mag * 64'(g) + 64'd32768) >> 16;
        return (v < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] window_sample(input logic signed [63:0] v,
                                                         input logic [63:0] t,
                                                         input logic [63:0] pick,
                                                         input logic [63:0] after,
                                                         input logic [63:0] lead);
        logic [63:0] late;
        late = pick + after;
        if (t >= late) v = apply_gain(v, taper_gain(t - late));
        // before window only exists when it does not reach below time zero
        if (pick >= lead && t <= pick - lead)
            v = apply_gain(v, taper_gain(pick - lead - t));
        return v;
    endfunction

    function automatic logic [63:0] t_at(input logic [IDX_W-1:0] idx);
        return 64'(idx) * 64'(cfg_period);
    endfunction

    function automatic logic signed [DATA_W-1:0] tapered_sample(input t_sample s);
        logic [63:0]        t;
        logic signed [63:0] v;
        logic signed [63:0] acc;
        t = t_at(s.index);
        v = s.value;
        // a 16-bit index can never exceed the trace length, so only the low end passes
        if (s.index < 2) begin
            acc = v;
        end else if (cfg_mode == MODE_TRACE) begin
            acc = window_sample(v, t, 64'(s.first_pick), 64'(s.first_after),
                                64'(s.first_before));
        end else if (cfg_mode == MODE_DUAL) begin
            acc = window_sample(v, t, 64'(s.first_pick), 64'(s.first_after),
                                64'(s.first_before))
                + window_sample(v, t, 64'(s.second_pick), 64'(s.second_after),
                                64'(s.second_before));
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        end else begin
            acc = window_sample(v, t, 64'(s.first_pick), 64'(cfg_after), 64'(cfg_before));
        end
        return acc[DATA_W-1:0];
    endfunction

    // ---------------------------------------------------------------- random helpers

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // roughly log-uniform magnitude over the whole 32-bit range
    function automatic logic [31:0] spread();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] near_pick(input logic [63:0] t);
        logic [63:0] d;
        logic [63:0] s;
        if (t > 64'hFFFF_FFFF || $urandom_range(0, 9) == 0) return $urandom;
        d = 64'(spread());
        if ($urandom_range(0, 1)) begin
            s = t + d;
            return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        end
        return (t >= d) ? 32'(t - d) : 32'd0;
    endfunction

    function automatic t_sample random_sample();
        t_sample     s;
        int unsigned r;
        logic [63:0] t;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0: s.value = 32'h7FFF_FFFF;
                1: s.value = 32'h8000_0000;
                2: s.value = 32'h0;
                default: s.value = 32'hFFFF_FFFF;
            endcase
        end else begin
            s.value = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 6)       s.index = IDX_W'($urandom_range(0, 1));
        else if (r < 20) s.index = IDX_W'($urandom_range(0, 65535));
        else             s.index = IDX_W'($urandom_range(2, 4000));
        t = t_at(s.index);
        s.first_pick    = near_pick(t);
        s.first_after   = spread();
        s.first_before  = spread();
        s.second_pick   = near_pick(t);
        s.second_after  = spread();
        s.second_before = spread();
        return s;
    endfunction

    // ---------------------------------------------------------------- stimulus tasks

    task automatic reg_write(input t_reg_idx r, input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            REG_MODE:   cfg_mode   = v[MODE_W-1:0];
            REG_PERIOD: cfg_period = v;
            REG_RATE:   cfg_rate   = v[23:0];
            REG_AFTER:  cfg_after  = v;
            REG_BEFORE: cfg_before = v;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the whole register file; junk in the unused upper bits must be dropped.
    task automatic set_config(input logic [MODE_W-1:0] mode, input logic [31:0] period,
                              input logic [23:0] rate, input logic [31:0] after,
                              input logic [31:0] lead);
        reg_write(REG_MODE,   {30'($urandom), mode});
        reg_write(REG_PERIOD, period);
        reg_write(REG_RATE,   {8'($urandom), rate});
        reg_write(REG_AFTER,  after);
        reg_write(REG_BEFORE, lead);
    endtask

    task automatic push_sample(input logic [31:0] val, input logic [IDX_W-1:0] idx,
                               input logic [31:0] p1, input logic [31:0] a1,
                               input logic [31:0] b1, input logic [31:0] p2,
                               input logic [31:0] a2, input logic [31:0] b2);
        t_sample s;
        s = '{val, idx, p1, a1, b1, p2, a2, b2};
        samples_to_send.push_back(s);
        queued_cnt++;
    endtask

    // Hold until every queued sample has come back, then let the pipeline settle.
    task automatic drain();
        while (out_cnt < queued_cnt) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- sender

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (tx_gap > 0) begin
                in_valid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (samples_to_send.size() > 0) begin
                cur      <= samples_to_send.pop_front();
                in_valid <= 1'b1;
                tx_gap   <= tx_steady ? 0 : idle_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // One long hold-off once the stream is well under way fills the pipeline and
    // forces back-pressure onto the input side.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end else if (!long_hold_done && in_cnt >= HOLD_AT) begin
            out_ready      <= 1'b0;
            rx_hold        <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (rx_steady) begin
            out_ready <= 1'b1;
        end else begin
            int unsigned g;
            g = idle_gap();
            out_ready <= (g == 0);
            if (g > 0) rx_hold <= g - 1;
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // retire the oldest expectation first: an output can never be the
            // sample accepted on this same edge
            if (o_out_valid && out_ready) begin
                out_cnt++;
                if (tapered_due.size() == 0) begin
                    $display("%0t: unexpected output transfer, got %0d", $time,
                             o_tapered_value);
                    errors++;
                end else begin
                    logic signed [DATA_W-1:0] want;
                    want = tapered_due.pop_front();
                    if (o_tapered_value !== want) begin
                        $display("%0t: tapered_value mismatch, expected %0d got %0d",
                                 $time, want, o_tapered_value);
                        errors++;
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                tapered_due.push_back(tapered_sample(cur));
                in_cnt++;
            end
            in_taken <= in_valid && o_in_ready;
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (psel && penable && pwrite && pready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        logic [63:0] t;
        logic [MODE_W-1:0] mode_cycle [4];
        logic [31:0] period;
        logic [23:0] rate;
        logic [31:0] after;
        logic [31:0] lead;
        int unsigned p;
        int unsigned n;

        mode_cycle = '{MODE_FIXED, MODE_TRACE, MODE_DUAL, MODE_ALIAS};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: fixed lengths of zero, 1049 period, unit rate.
        // Per-trace lengths and second window are ignored here, so fill them with junk.
        push_sample(32'h7FFF_FFFF, 16'd0, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        push_sample(32'h8000_0000, 16'd1, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        t = t_at(16'd2);                        // zero excess on both sides
        push_sample(32'h8000_0000, 16'd2, t[31:0], $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        push_sample(32'h7FFF_FFFF, 16'd65535, 32'd0, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        t = t_at(16'd1000);                     // one second late, then one early
        push_sample(-32'sd12345, 16'd1000, 32'(t - (64'd1 << 20)), $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        push_sample(32'h8000_0000, 16'd1000, 32'(t + (64'd1 << 20)), $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        t = t_at(16'd500);                      // exponent rounds to zero
        push_sample(32'hFFFF_FFFF, 16'd500, 32'(t - 64'd3), $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        drain();

        // Zero rate: nothing is ever damped.
        set_config(MODE_TRACE, 32'd1049, 24'd0, 32'd0, 32'd0);
        push_sample(32'h8000_0000, 16'd3000, 32'd0, 32'd0, 32'd0,
                    $urandom, $urandom, $urandom);
        push_sample(32'h7FFF_FFFF, 16'd40, 32'hFFFF_FFFF, 32'd0, 32'd0,
                    $urandom, $urandom, $urandom);
        drain();

        // Per-trace lengths, rate 2.5 per second.
        set_config(MODE_TRACE, 32'd1049, 24'd163840, $urandom, $urandom);
        t = t_at(16'd10);                       // before window would start below zero
        push_sample(32'd987654321, 16'd10, 32'(t + 64'd5000), 32'd0, 32'(t + 64'd5001),
                    $urandom, $urandom, $urandom);
        push_sample(32'd987654321, 16'd10, 32'(t + 64'd5000), 32'd0, 32'd100,
                    $urandom, $urandom, $urandom);
        t = t_at(16'd2000);
        push_sample(-32'sd55555555, 16'd2000, 32'(t - (64'd1 << 21)), 32'd1 << 20, 32'd0,
                    $urandom, $urandom, $urandom);
        push_sample(32'h8000_0000, 16'd2000, t[31:0], 32'd1000, 32'd1000,
                    $urandom, $urandom, $urandom);
        drain();

        // Two windows: saturation both ways, one copy damped, leading sample.
        set_config(MODE_DUAL, 32'd1049, 24'd65536, $urandom, $urandom);
        t = t_at(16'd100);
        push_sample(32'h7FFF_FFFF, 16'd100, t[31:0], 32'd1 << 24, 32'd1 << 24,
                    t[31:0], 32'd1 << 24, 32'd1 << 24);
        push_sample(32'h8000_0000, 16'd100, t[31:0], 32'd1 << 24, 32'd1 << 24,
                    t[31:0], 32'd1 << 24, 32'd1 << 24);
        push_sample(32'd1000000, 16'd100, t[31:0], 32'd1 << 24, 32'd1 << 24,
                    32'(t - (64'd3 << 19)), 32'd0, 32'd0);
        push_sample(32'h7FFF_FFFF, 16'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        drain();

        // Unused mode code with fixed lengths and the fastest rate.
        set_config(MODE_ALIAS, 32'd1049, 24'hFF_FFFF, 32'd1 << 20, 32'd1 << 19);
        t = t_at(16'd2000);
        push_sample(32'h7FFF_FFFF, 16'd2000, 32'(t - (64'd1 << 20) - 64'd1), $urandom,
                    $urandom, $urandom, $urandom, $urandom);
        push_sample(32'h8000_0000, 16'd2000, 32'(t + (64'd1 << 19) + 64'd2), $urandom,
                    $urandom, $urandom, $urandom, $urandom);
        push_sample(32'd123456789, 16'd2000, t[31:0], $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        drain();

        // Longest period, slowest non-zero rate: excess past the cut-off and one well below it.
        set_config(MODE_FIXED, 32'hFFFF_FFFF, 24'd1, 32'd0, 32'd0);
        push_sample(32'h7FFF_FFFF, 16'd65535, 32'd0, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        push_sample(32'h7FFF_FFFF, 16'd2, 32'hFFFF_FFFF, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        drain();

        // Zero rate with an excess past the cut-off: still undamped.
        set_config(MODE_FIXED, 32'hFFFF_FFFF, 24'd0, 32'd0, 32'd0);
        push_sample(32'h7FFF_FFFF, 16'd65535, 32'd0, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        drain();

        // Random phases; the first few pin the register extremes.
        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       period = 32'd1;
                1:       period = 32'hFFFF_FFFF;
                default: begin
                    n = $urandom_range(0, 99);
                    if (n < 60)      period = $urandom_range(1, 4096);
                    else if (n < 85) period = $urandom_range(1, 32'd1 << 20);
                    else             period = $urandom_range(1, 32'hFFFF_FFFF);
                end
            endcase
            case (p)
                2:       rate = 24'd0;
                3:       rate = 24'hFF_FFFF;
                default: rate = 24'($urandom) >> $urandom_range(0, 23);
            endcase
            case (p)
                4: begin
                    after = 32'hFFFF_FFFF;
                    lead  = 32'hFFFF_FFFF;
                end
                5: begin
                    after = 32'd0;
                    lead  = 32'd0;
                end
                default: begin
                    after = spread();
                    lead  = spread();
                end
            endcase
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            set_config(mode_cycle[p % 4], period, rate, after, lead);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                samples_to_send.push_back(random_sample());
                queued_cnt++;
            end
            drain();
        end

        if (tapered_due.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, tapered_due.size());
        if (errors == 0 && tapered_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/stwt_pkg.sv
rtl/core/stwt_regs.sv
rtl/core/stwt_excess.sv
rtl/core/stwt_taper.sv
rtl/core/stwt_combine.sv
rtl/core/seismic_time_window_taper_top.sv
tb/sv/tb.sv
